[hw/rtl/fixed_size_run_free_list_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run free list allocator
// Concurrent checks sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_SIZE_RUN_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_SIZE_RUN_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FRFA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/frfa_pkg.sv]
// ----------------------------------------------------------------------------
// frfa_pkg
// Types, codes and sizes shared by the run free list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frfa_pkg;

   localparam int FRFA_QUEUE_DEPTH = 64;
   localparam int ADDRESS_BITS     = 32;

   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int OSIZE_W   = 21;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam int ADDR_KEEP = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_KEEP) - 64'd1);

   localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MEMORY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CONFIG    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ARENA_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OBJ_SIZE     = 2'd2;

   localparam int DIVIDEND_W = COUNT_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [COUNT_W-1:0] count;
   } frfa_run_type;

   typedef struct packed {
      logic load;
      logic shift;
   } frfa_cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DIV    = 3'b010,
      S_FINISH = 3'b100
   } frfa_state_type;

endpackage

[hw/rtl/frfa_req_if.sv]
// ----------------------------------------------------------------------------
// frfa_req_if
// Request channel: command and returned object address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frfa_req_if import frfa_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output command, output free_address, input ready);
   modport sink (input valid, input command, input free_address, output ready);

endinterface

[hw/rtl/frfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// frfa_rsp_if
// Response channel: allocated address and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frfa_rsp_if import frfa_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output address, output status, input ready);
   modport sink (input valid, input address, input status, output ready);

endinterface

[hw/rtl/frfa_cell.sv]
// ----------------------------------------------------------------------------
// frfa_cell
// One slot of the run queue: loads a new run or takes its neighbor's run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frfa_cell import frfa_pkg::*; (
   input  logic              clock,
   input  frfa_cell_ctl_type ctl,
   input  frfa_run_type      load_run,
   input  frfa_run_type      next_run,
   output frfa_run_type      run_q
);

   frfa_run_type run_ff;
   frfa_run_type run_in;

   always_comb begin
      run_in = run_ff;
      if (ctl.load) begin
         run_in = load_run;
      end else if (ctl.shift) begin
         run_in = next_run;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign run_q = run_ff;

endmodule

[hw/rtl/frfa_divider.sv]
// ----------------------------------------------------------------------------
// frfa_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frfa_divider import frfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [OSIZE_W-1:0]    divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [OSIZE_W-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [OSIZE_W-1:0]    dvs_ff, dvs_in;

   logic [OSIZE_W:0] trial;
   logic [OSIZE_W:0] diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[OSIZE_W-1:0] : trial[OSIZE_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/fixed_size_run_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_size_run_free_list_allocator
// Fixed-size object allocator over a FIFO of free runs held in a cell chain.
// ----------------------------------------------------------------------------
// Free space is a queue of runs (start address, object count) held in a row
// of QUEUE_DEPTH cells; the head sits in cell zero and a pop moves every run
// one cell toward the head. Allocate, free and the unused command update the
// queue and, on allocate, form the product of the head count minus one and
// the object size; the response register then adds the run start. Initialize
// waits on the bit-serial divider that divides the arena length by the object
// size one quotient bit per cycle. One request is in flight at a time; a
// finished response stays in the output register until it is taken.
`timescale 1ns / 1ps
`include "fixed_size_run_free_list_allocator_macros.svh"

module fixed_size_run_free_list_allocator import frfa_pkg::*; #(
   parameter int QUEUE_DEPTH = FRFA_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   frfa_req_if.sink             req_chan,
   frfa_rsp_if.source           rsp_chan
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frfa_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]   arena_ff, arena_in;
   logic [OSIZE_W-1:0]  osize_ff, osize_in;
   logic [OSIZE_W-1:0]  pool_size_ff, pool_size_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [ADDR_W-1:0]   product_ff, product_in;
   logic                res_alloc_ff, res_alloc_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   frfa_run_type      cell_q   [QUEUE_DEPTH];
   frfa_run_type      cell_nxt [QUEUE_DEPTH];
   frfa_cell_ctl_type cell_ctl [QUEUE_DEPTH];

   logic              req_acc;
   logic              load_en;
   logic              shift_en;
   logic [IDX_W-1:0]  wr_pos;
   frfa_run_type      load_run;
   logic [COUNT_W-1:0] alloc_cnt;
   logic              div_start;
   logic              div_done;
   logic [COUNT_W-1:0] div_quotient;

   // run queue
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign cell_nxt[i] = '0;
      end else begin : g_mid
         assign cell_nxt[i] = cell_q[i+1];
      end
      assign cell_ctl[i] = '{load: load_en && (wr_pos == IDX_W'(i)), shift: shift_en};

      frfa_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .load_run (load_run),
         .next_run (cell_nxt[i]),
         .run_q    (cell_q[i])
      );
   end

   frfa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (arena_ff),
      .divisor  (osize_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_acc = (state_ff == S_IDLE) && req_chan.valid;

   // configuration registers
   always_comb begin
      base_in  = base_ff;
      arena_in = arena_ff;
      osize_in = osize_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_BASE_ADDRESS: base_in = csr_wdata;
            REG_ARENA_LENGTH: arena_in = csr_wdata;
            REG_OBJ_SIZE:     osize_in = csr_wdata[OSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // request sequencing
   always_comb begin
      state_in      = state_ff;
      pool_size_in  = pool_size_ff;
      held_in       = held_ff;
      start_in      = start_ff;
      product_in    = product_ff;
      res_alloc_in  = res_alloc_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      load_en       = 1'b0;
      shift_en      = 1'b0;
      wr_pos        = '0;
      load_run      = '{start: req_chan.free_address, count: COUNT_W'(1)};
      div_start     = 1'b0;
      alloc_cnt     = cell_q[0].count - COUNT_W'(1);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               res_alloc_in  = 1'b0;
               res_status_in = STATUS_OK;
               state_in      = S_FINISH;
               case (req_chan.command)
                  CMD_ALLOCATE: begin
                     if (held_ff == '0) begin
                        res_status_in = STATUS_OUT_OF_MEMORY;
                     end else begin
                        shift_en     = 1'b1;
                        wr_pos       = IDX_W'(held_ff - CNT_W'(1));
                        load_run     = '{start: cell_q[0].start, count: alloc_cnt};
                        load_en      = (alloc_cnt != '0);
                        held_in      = held_ff - CNT_W'(1) + CNT_W'(alloc_cnt != '0);
                        start_in     = cell_q[0].start;
                        product_in   = ADDR_W'(alloc_cnt * COUNT_W'(pool_size_ff));
                        res_alloc_in = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (held_ff == CNT_W'(QUEUE_DEPTH)) begin
                        res_status_in = STATUS_QUEUE_FULL;
                     end else begin
                        load_en = 1'b1;
                        wr_pos  = IDX_W'(held_ff);
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
                  CMD_INIT: begin
                     if (osize_ff == '0 || ADDR_W'(osize_ff) >= arena_ff) begin
                        res_status_in = STATUS_BAD_CONFIG;
                     end else begin
                        div_start    = 1'b1;
                        pool_size_in = osize_ff;
                        state_in     = S_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               load_en  = 1'b1;
               wr_pos   = '0;
               load_run = '{start: base_ff, count: div_quotient};
               held_in  = CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_alloc_ff ? ((start_ff + product_ff) & ADDR_MASK) : '0;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         arena_ff     <= '0;
         osize_ff     <= '0;
         pool_size_ff <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         arena_ff     <= arena_in;
         osize_ff     <= osize_in;
         pool_size_ff <= pool_size_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff      <= start_in;
      product_ff    <= product_in;
      res_alloc_ff  <= res_alloc_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.address = rsp_addr_ff;
   assign rsp_chan.status  = rsp_status_ff;

   `FRFA_ASSERT_NOW(a_held_bounded, 1'b1, held_ff <= CNT_W'(QUEUE_DEPTH), "run count above depth")
   `FRFA_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == S_DIV, "divider done outside init")
   `FRFA_ASSERT_NEXT(a_free_push, req_acc && req_chan.command == CMD_FREE && held_ff != CNT_W'(QUEUE_DEPTH), held_ff == $past(held_ff) + CNT_W'(1), "free did not push a run")
   `FRFA_ASSERT_NEXT(a_oom_when_empty, req_acc && req_chan.command == CMD_ALLOCATE && held_ff == '0, res_status_ff == STATUS_OUT_OF_MEMORY && !res_alloc_ff, "empty allocate not flagged")

endmodule
